// ===== hw/rtl/dns_response_address_extractor_unit_macros.svh =====
// Assertion macros for the DNS response address extractor.
// Both macros expect signals named clk and arst_n in the calling scope.
`ifndef DNS_RESPONSE_ADDRESS_EXTRACTOR_UNIT_MACROS_SVH
`define DNS_RESPONSE_ADDRESS_EXTRACTOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DRAE_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DRAE_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ===== hw/rtl/drae_pkg.sv =====
// Types and constants for the DNS response address extractor.
// No dependencies; imported by the top level.
package drae_pkg;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_NAME,
		PH_POINTER,
		PH_FIXED,
		PH_RDATA,
		PH_DONE
	} phase_t;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_AGAIN  = 3'd1;
	localparam logic [2:0] ST_FAIL   = 3'd2;
	localparam logic [2:0] ST_NONAME = 3'd3;
	localparam logic [2:0] ST_TRUNC  = 3'd4;

	localparam logic [1:0] KIND_IPV4   = 2'd0;
	localparam logic [1:0] KIND_IPV6   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [1:0] FILT_BOTH = 2'd0;
	localparam logic [1:0] FILT_IPV4 = 2'd1;
	localparam logic [1:0] FILT_IPV6 = 2'd2;

	localparam logic [15:0] TYPE_A    = 16'd1;
	localparam logic [15:0] TYPE_AAAA = 16'd28;

	localparam logic [3:0] RCODE_SERVFAIL = 4'd2;
	localparam logic [3:0] RCODE_NXDOMAIN = 4'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [2:0]  status;
		logic        last;
	} result_t;

endpackage

// ===== hw/rtl/dns_response_address_extractor_unit.sv =====
// Each result is registered: it is written into the result queue when its byte is accepted.
// Throughput: one message byte per cycle; a byte yields at most two results, which
// go into a four-entry result queue, and input is held off while fewer than two
// entries are free. Reset (arst_n low) clears the parse state, the filter and the queue.
// Depends on drae_pkg and the assertion macro header.
`include "dns_response_address_extractor_unit_macros.svh"

module dns_response_address_extractor_unit
	import drae_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
	input  logic         s_axis_tlast,   // end_of_message
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [135:0] m_axis_tdata,   // [63:0] address_high, [127:64] address_low,
	                                     // [130:128] status, rest zero
	output logic [1:0]   m_axis_tuser,   // [1:0] kind
	output logic         m_axis_tlast,   // last
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_data        // family_filter
);

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	logic [1:0]  filter_q;

	phase_t      phase_q, phase_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [15:0] question_count_q, question_count_d;
	logic [15:0] answer_count_q, answer_count_d;
	logic [15:0] record_index_q, record_index_d;
	logic [7:0]  label_q, label_d;
	logic [15:0] record_type_q, record_type_d;
	logic [15:0] rdata_length_q, rdata_length_d;
	logic [63:0] shift_hi_q, shift_hi_d;
	logic [63:0] shift_lo_q, shift_lo_d;
	logic        found_any_q, found_any_d;
	logic        hdr_resp_q, hdr_resp_d;
	logic [3:0]  hdr_rcode_q, hdr_rcode_d;
	logic        in_answer_q, in_answer_d;

	logic        acc;
	logic [7:0]  b;
	logic [15:0] byte_inc;
	logic [15:0] rdlen_full;
	logic [15:0] ri_next;
	logic [63:0] shift_hi_next, shift_lo_next;
	logic        is_a, is_aaaa;
	logic        rec_done;

	logic        addr_ev;
	logic [1:0]  addr_kind;
	logic [63:0] addr_hi, addr_lo;
	logic        stat_ev;
	logic [2:0]  stat_code;

	result_t     r0, r1;
	logic [1:0]  n_res;

	result_t     queue_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;
	logic [QAW:0]   push_n;
	logic           pop;

	assign cfg_ready = 1'b1;

	assign acc      = s_axis_tvalid && s_axis_tready;
	assign b        = s_axis_tdata;
	assign byte_inc = byte_count_q + 16'd1;
	assign rdlen_full    = {rdata_length_q[15:8], b};
	assign ri_next       = record_index_q + 16'd1;
	assign shift_hi_next = {shift_hi_q[55:0], shift_lo_q[63:56]};
	assign shift_lo_next = {shift_lo_q[55:0], b};
	assign is_a    = (record_type_q == TYPE_A) &&
	                 (filter_q == FILT_BOTH || filter_q == FILT_IPV4);
	assign is_aaaa = (record_type_q == TYPE_AAAA) &&
	                 (filter_q == FILT_BOTH || filter_q == FILT_IPV6);

	// Next parse state and the events raised by the current byte.
	always_comb begin
		phase_d          = phase_q;
		byte_count_d     = byte_count_q;
		question_count_d = question_count_q;
		answer_count_d   = answer_count_q;
		record_index_d   = record_index_q;
		label_d          = label_q;
		record_type_d    = record_type_q;
		rdata_length_d   = rdata_length_q;
		shift_hi_d       = shift_hi_q;
		shift_lo_d       = shift_lo_q;
		found_any_d      = found_any_q;
		hdr_resp_d       = hdr_resp_q;
		hdr_rcode_d      = hdr_rcode_q;
		in_answer_d      = in_answer_q;
		addr_ev          = 1'b0;
		addr_kind        = KIND_IPV4;
		addr_hi          = '0;
		addr_lo          = '0;
		stat_ev          = 1'b0;
		stat_code        = ST_OK;
		rec_done         = 1'b0;

		unique case (phase_q)
			PH_HEADER: begin
				byte_count_d = byte_inc;
				priority if (byte_count_q == 16'd2) begin
					hdr_resp_d = b[7];
				end else if (byte_count_q == 16'd3) begin
					hdr_rcode_d = b[3:0];
				end else if (byte_count_q == 16'd4) begin
					question_count_d = {b, 8'h00};
				end else if (byte_count_q == 16'd5) begin
					question_count_d = {question_count_q[15:8], b};
				end else if (byte_count_q == 16'd6) begin
					answer_count_d = {b, 8'h00};
				end else if (byte_count_q == 16'd7) begin
					answer_count_d = {answer_count_q[15:8], b};
				end else if (byte_count_q == 16'd11) begin
					priority if (!hdr_resp_q) begin
						stat_ev   = 1'b1;
						stat_code = ST_AGAIN;
					end else if (hdr_rcode_q == RCODE_SERVFAIL) begin
						stat_ev   = 1'b1;
						stat_code = ST_AGAIN;
					end else if (hdr_rcode_q == RCODE_NXDOMAIN) begin
						stat_ev   = 1'b1;
						stat_code = ST_NONAME;
					end else if (hdr_rcode_q != 4'd0) begin
						stat_ev   = 1'b1;
						stat_code = ST_FAIL;
					end else if (answer_count_q == 16'd0) begin
						stat_ev   = 1'b1;
						stat_code = ST_NONAME;
					end else begin
						in_answer_d    = (question_count_q == 16'd0);
						record_index_d = '0;
						label_d        = '0;
						phase_d        = PH_NAME;
					end
					if (stat_ev) begin
						phase_d = PH_DONE;
					end
				end else begin
				end
			end
			PH_NAME: begin
				priority if (label_q != 8'd0) begin
					label_d = label_q - 8'd1;
				end else if (b == 8'd0) begin
					phase_d      = PH_FIXED;
					byte_count_d = '0;
				end else if (b[7:6] == 2'b11) begin
					phase_d = PH_POINTER;
				end else begin
					label_d = b;
				end
			end
			PH_POINTER: begin
				phase_d      = PH_FIXED;
				byte_count_d = '0;
			end
			PH_FIXED: begin
				byte_count_d = byte_inc;
				if (!in_answer_q) begin
					// Question entry: type and class follow the name.
					rec_done = (byte_count_q == 16'd3);
				end else begin
					priority if (byte_count_q == 16'd0) begin
						record_type_d = {b, 8'h00};
					end else if (byte_count_q == 16'd1) begin
						record_type_d = {record_type_q[15:8], b};
					end else if (byte_count_q == 16'd8) begin
						rdata_length_d = {b, 8'h00};
					end else if (byte_count_q == 16'd9) begin
						rdata_length_d = rdlen_full;
						priority if ((is_a && rdlen_full < 16'd4) ||
						             (is_aaaa && rdlen_full < 16'd16)) begin
							stat_ev   = 1'b1;
							stat_code = ST_FAIL;
							phase_d   = PH_DONE;
						end else if (rdlen_full == 16'd0) begin
							rec_done = 1'b1;
						end else begin
							phase_d      = PH_RDATA;
							byte_count_d = '0;
							shift_hi_d   = '0;
							shift_lo_d   = '0;
						end
					end else begin
					end
				end
			end
			PH_RDATA: begin
				byte_count_d = byte_inc;
				if (byte_count_q[15:4] == 12'd0) begin
					shift_hi_d = shift_hi_next;
					shift_lo_d = shift_lo_next;
				end
				if (byte_count_q == 16'd3 && is_a) begin
					addr_ev     = 1'b1;
					addr_kind   = KIND_IPV4;
					addr_lo     = {32'h0, shift_lo_next[31:0]};
					found_any_d = 1'b1;
				end else if (byte_count_q == 16'd15 && is_aaaa) begin
					addr_ev     = 1'b1;
					addr_kind   = KIND_IPV6;
					addr_hi     = shift_hi_next;
					addr_lo     = shift_lo_next;
					found_any_d = 1'b1;
				end
				rec_done = (byte_inc == rdata_length_q);
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (rec_done) begin
			record_index_d = ri_next;
			label_d        = '0;
			phase_d        = PH_NAME;
			if (!in_answer_q) begin
				if (ri_next == question_count_q) begin
					in_answer_d    = 1'b1;
					record_index_d = '0;
				end
			end else if (ri_next == answer_count_q) begin
				stat_ev   = 1'b1;
				stat_code = found_any_d ? ST_OK : ST_NONAME;
				phase_d   = PH_DONE;
			end
		end

		// End of message: report truncation if no status went out, then start over.
		if (s_axis_tlast) begin
			if (!stat_ev && phase_q != PH_DONE) begin
				stat_ev   = 1'b1;
				stat_code = ST_TRUNC;
			end
			phase_d          = PH_HEADER;
			byte_count_d     = '0;
			question_count_d = '0;
			answer_count_d   = '0;
			record_index_d   = '0;
			label_d          = '0;
			record_type_d    = '0;
			rdata_length_d   = '0;
			shift_hi_d       = '0;
			shift_lo_d       = '0;
			found_any_d      = 1'b0;
			hdr_resp_d       = 1'b0;
			hdr_rcode_d      = '0;
			in_answer_d      = 1'b0;
		end
	end

	// Result records for the current byte: an address always precedes the status.
	always_comb begin
		r0    = '0;
		r1    = '0;
		n_res = 2'd0;
		if (addr_ev) begin
			r0.kind         = addr_kind;
			r0.address_high = addr_hi;
			r0.address_low  = addr_lo;
			n_res           = 2'd1;
			if (stat_ev) begin
				r1.kind   = KIND_STATUS;
				r1.status = stat_code;
				r1.last   = 1'b1;
				n_res     = 2'd2;
			end
		end else if (stat_ev) begin
			r0.kind   = KIND_STATUS;
			r0.status = stat_code;
			r0.last   = 1'b1;
			n_res     = 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_q <= FILT_BOTH;
		end else if (cfg_valid && cfg_ready) begin
			filter_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_HEADER;
			byte_count_q     <= '0;
			question_count_q <= '0;
			answer_count_q   <= '0;
			record_index_q   <= '0;
			label_q          <= '0;
			record_type_q    <= '0;
			rdata_length_q   <= '0;
			shift_hi_q       <= '0;
			shift_lo_q       <= '0;
			found_any_q      <= 1'b0;
			hdr_resp_q       <= 1'b0;
			hdr_rcode_q      <= '0;
			in_answer_q      <= 1'b0;
		end else if (acc) begin
			phase_q          <= phase_d;
			byte_count_q     <= byte_count_d;
			question_count_q <= question_count_d;
			answer_count_q   <= answer_count_d;
			record_index_q   <= record_index_d;
			label_q          <= label_d;
			record_type_q    <= record_type_d;
			rdata_length_q   <= rdata_length_d;
			shift_hi_q       <= shift_hi_d;
			shift_lo_q       <= shift_lo_d;
			found_any_q      <= found_any_d;
			hdr_resp_q       <= hdr_resp_d;
			hdr_rcode_q      <= hdr_rcode_d;
			in_answer_q      <= in_answer_d;
		end
	end

	// Result queue.
	assign pop    = m_axis_tvalid && m_axis_tready;
	assign push_n = acc ? {{(QAW - 1){1'b0}}, n_res} : '0;

	// Room for the two results that one request can produce.
	assign s_axis_tready = (count_q <= (QAW + 1)'(QDEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n[QAW-1:0];
			rd_ptr_q <= rd_ptr_q + QAW'(pop);
			count_q  <= count_q + push_n - (QAW + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (acc && n_res != 2'd0) begin
			queue_q[wr_ptr_q] <= r0;
		end
		if (acc && n_res == 2'd2) begin
			queue_q[wr_ptr_q + QAW'(1)] <= r1;
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = {5'b0, queue_q[rd_ptr_q].status,
	                        queue_q[rd_ptr_q].address_low,
	                        queue_q[rd_ptr_q].address_high};
	assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
	assign m_axis_tlast  = queue_q[rd_ptr_q].last;

	`DRAE_ASSERT_SAME(a_queue_bound, 1'b1, count_q <= (QAW + 1)'(QDEPTH), "result queue overflow")
	`DRAE_ASSERT_NEXT(a_eom_restart, acc && s_axis_tlast, phase_q == PH_HEADER && byte_count_q == 16'd0, "no restart after end of message")
	`DRAE_ASSERT_SAME(a_done_no_addr, acc && phase_q == PH_DONE, !addr_ev && !stat_ev, "result after final status")
	`DRAE_ASSERT_NEXT(a_push_visible, acc && n_res != 2'd0, m_axis_tvalid, "pushed result not presented")

endmodule

// ===== test/dns_response_address_extractor_unit_tb.sv =====
// Self-checking testbench for the DNS response address extractor.
// It streams response messages byte by byte into the block and checks every result against an
// in-bench parser of the same format. Depends on drae_pkg and the top-level RTL.
`timescale 1ns / 1ps

module dns_response_address_extractor_unit_tb;
	import drae_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 200;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [15:0] TYPE_CNAME = 16'd5;
	localparam logic [1:0] FILT_NONE = 2'd3;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [7:0]   s_axis_tdata = 8'h00;
	logic         s_axis_tlast = 1'b0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [135:0] m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	logic         m_axis_tlast;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_data = 2'd0;

	dns_response_address_extractor_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #5 clk = ~clk;

	// Parser state mirrored by the bench.
	logic [1:0]  filter_setting = FILT_BOTH;
	phase_t      pr_phase;
	logic [15:0] pr_count, pr_qdcount, pr_ancount, pr_rec, pr_rtype, pr_rdlen, pr_flags;
	logic [7:0]  pr_label_left;
	logic [63:0] pr_addr_hi, pr_addr_lo;
	bit          pr_found, pr_done, pr_in_answer;
	result_t     awaited_results[$];

	logic [7:0]  msg_bytes[$];
	bit          allow_gaps = 1'b1;
	// While set, put_name writes every name in directed messages as a two-byte pointer.
	bit          short_names = 1'b1;
	int          stall_left = 0;
	int          cycle_count = 0;
	int          error_count = 0;
	int          results_checked = 0;
	int          bytes_sent = 0;
	int          messages_sent = 0;

	task automatic clear_parse_state();
		pr_phase = PH_HEADER;
		pr_count = '0;
		pr_qdcount = '0;
		pr_ancount = '0;
		pr_rec = '0;
		pr_label_left = '0;
		pr_rtype = '0;
		pr_rdlen = '0;
		pr_addr_hi = '0;
		pr_addr_lo = '0;
		pr_found = 1'b0;
		pr_done = 1'b0;
		pr_flags = '0;
		pr_in_answer = 1'b0;
	endtask

	task automatic push_result(input logic [1:0] kind, input logic [63:0] hi,
			input logic [63:0] lo, input logic [2:0] st, input logic lst);
		result_t r;
		r.kind = kind;
		r.address_high = hi;
		r.address_low = lo;
		r.status = st;
		r.last = lst;
		awaited_results.push_back(r);
	endtask

	task automatic close_message(input logic [2:0] st);
		push_result(KIND_STATUS, 64'd0, 64'd0, st, 1'b1);
		pr_done = 1'b1;
		pr_phase = PH_DONE;
	endtask

	function automatic bit wanted_a();
		return pr_rtype == TYPE_A && (filter_setting == FILT_BOTH || filter_setting == FILT_IPV4);
	endfunction

	function automatic bit wanted_aaaa();
		return pr_rtype == TYPE_AAAA &&
			(filter_setting == FILT_BOTH || filter_setting == FILT_IPV6);
	endfunction

	task automatic begin_answers();
		pr_in_answer = 1'b1;
		pr_rec = '0;
		pr_label_left = '0;
		pr_phase = PH_NAME;
	endtask

	task automatic close_record();
		pr_rec = pr_rec + 16'd1;
		pr_label_left = '0;
		pr_phase = PH_NAME;
		if (!pr_in_answer) begin
			if (pr_rec == pr_qdcount)
				begin_answers();
		end else if (pr_rec == pr_ancount) begin
			close_message(pr_found ? ST_OK : ST_NONAME);
		end
	endtask

	task automatic parse_response_byte(input logic [7:0] b, input logic eom);
		logic [15:0] idx;
		idx = pr_count;
		case (pr_phase)
			PH_HEADER: begin
				pr_count = pr_count + 16'd1;
				case (idx)
					16'd2: pr_flags = {b, 8'h00};
					16'd3: pr_flags[7:0] = b;
					16'd4: pr_qdcount = {b, 8'h00};
					16'd5: pr_qdcount[7:0] = b;
					16'd6: pr_ancount = {b, 8'h00};
					16'd7: pr_ancount[7:0] = b;
					16'd11: begin
						if (!pr_flags[15])
							close_message(ST_AGAIN);
						else if (pr_flags[3:0] == RCODE_SERVFAIL)
							close_message(ST_AGAIN);
						else if (pr_flags[3:0] == RCODE_NXDOMAIN)
							close_message(ST_NONAME);
						else if (pr_flags[3:0] != 4'd0)
							close_message(ST_FAIL);
						else if (pr_ancount == 16'd0)
							close_message(ST_NONAME);
						else if (pr_qdcount == 16'd0)
							begin_answers();
						else begin
							pr_in_answer = 1'b0;
							pr_rec = '0;
							pr_label_left = '0;
							pr_phase = PH_NAME;
						end
					end
					default: ;
				endcase
			end
			PH_NAME: begin
				if (pr_label_left != 8'd0) begin
					pr_label_left = pr_label_left - 8'd1;
				end else if (b == 8'd0) begin
					pr_phase = PH_FIXED;
					pr_count = '0;
				end else if (b[7:6] == 2'b11) begin
					pr_phase = PH_POINTER;
				end else begin
					pr_label_left = b;
				end
			end
			PH_POINTER: begin
				pr_phase = PH_FIXED;
				pr_count = '0;
			end
			PH_FIXED: begin
				pr_count = pr_count + 16'd1;
				if (!pr_in_answer) begin
					// Question entries carry only type and class after the name.
					if (idx == 16'd3)
						close_record();
				end else begin
					case (idx)
						16'd0: pr_rtype = {b, 8'h00};
						16'd1: pr_rtype[7:0] = b;
						16'd8: pr_rdlen = {b, 8'h00};
						16'd9: begin
							pr_rdlen[7:0] = b;
							if ((wanted_a() && pr_rdlen < 16'd4) ||
									(wanted_aaaa() && pr_rdlen < 16'd16))
								close_message(ST_FAIL);
							else if (pr_rdlen == 16'd0)
								close_record();
							else begin
								pr_phase = PH_RDATA;
								pr_count = '0;
								pr_addr_hi = '0;
								pr_addr_lo = '0;
							end
						end
						default: ;
					endcase
				end
			end
			PH_RDATA: begin
				pr_count = pr_count + 16'd1;
				if (idx < 16'd16) begin
					pr_addr_hi = {pr_addr_hi[55:0], pr_addr_lo[63:56]};
					pr_addr_lo = {pr_addr_lo[55:0], b};
				end
				if (idx == 16'd3 && wanted_a()) begin
					push_result(KIND_IPV4, 64'd0, {32'd0, pr_addr_lo[31:0]}, ST_OK, 1'b0);
					pr_found = 1'b1;
				end else if (idx == 16'd15 && wanted_aaaa()) begin
					push_result(KIND_IPV6, pr_addr_hi, pr_addr_lo, ST_OK, 1'b0);
					pr_found = 1'b1;
				end
				if (pr_count == pr_rdlen)
					close_record();
			end
			default: ;
		endcase
		if (eom) begin
			if (!pr_done)
				close_message(ST_TRUNC);
			clear_parse_state();
		end
	endtask

	// Result side: random stall bursts while gaps are allowed.
	always @(negedge clk) begin
		if (allow_gaps && stall_left > 0) begin
			m_axis_tready = 1'b0;
			stall_left = stall_left - 1;
		end else if (allow_gaps && $urandom_range(0, 5) == 0) begin
			m_axis_tready = 1'b0;
			stall_left = $urandom_range(0, 6);
		end else begin
			m_axis_tready = 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.address_high = m_axis_tdata[63:0];
			got.address_low = m_axis_tdata[127:64];
			got.status = m_axis_tdata[130:128];
			got.last = m_axis_tlast;
			results_checked = results_checked + 1;
			if (awaited_results.size() == 0) begin
				error_count = error_count + 1;
				if (error_count <= 10)
					$display("%0t: result with none expected: kind %0d hi %h lo %h status %0d last %0d",
						$realtime, got.kind, got.address_high, got.address_low, got.status,
						got.last);
			end else begin
				want = awaited_results.pop_front();
				if (got.kind !== want.kind || got.address_high !== want.address_high ||
						got.address_low !== want.address_low || got.status !== want.status ||
						got.last !== want.last) begin
					error_count = error_count + 1;
					if (error_count <= 10) begin
						$display("%0t: mismatch, expected kind %0d hi %h lo %h status %0d last %0d",
							$realtime, want.kind, want.address_high, want.address_low,
							want.status, want.last);
						$display("%0t:             actual kind %0d hi %h lo %h status %0d last %0d",
							$realtime, got.kind, got.address_high, got.address_low,
							got.status, got.last);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Cycle limit reached with %0d results outstanding.", awaited_results.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Each call starts and ends at a falling edge.
	task automatic send_byte(input logic [7:0] b, input logic eom);
		if (allow_gaps && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = eom;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		parse_response_byte(b, eom);
		bytes_sent = bytes_sent + 1;
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	task automatic send_message();
		int n;
		n = msg_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(msg_bytes[i], i == n - 1);
		msg_bytes.delete();
		messages_sent = messages_sent + 1;
	endtask

	task automatic wait_until_idle();
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_family_filter(input logic [1:0] value);
		wait_until_idle();
		cfg_valid = 1'b1;
		cfg_data = value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		filter_setting = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic put16(input logic [15:0] v);
		msg_bytes.push_back(v[15:8]);
		msg_bytes.push_back(v[7:0]);
	endtask

	task automatic put_random(input int n);
		repeat (n) msg_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// Transaction ID, flags, the two counts, then the authority and additional counts.
	task automatic put_header(input logic [15:0] flags, input logic [15:0] qd,
			input logic [15:0] an);
		put_random(2);
		put16(flags);
		put16(qd);
		put16(an);
		put_random(4);
	endtask

	task automatic put_name();
		int labels, len;
		if (short_names || $urandom_range(0, 3) == 0) begin
			msg_bytes.push_back(8'hc0 | 8'($urandom_range(0, 63)));
			put_random(1);
		end else begin
			labels = $urandom_range(0, 3);
			repeat (labels) begin
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(64, 191) : $urandom_range(1, 6);
				msg_bytes.push_back(8'(len));
				put_random(len);
			end
			if ($urandom_range(0, 1) == 0) begin
				msg_bytes.push_back(8'h00);
			end else begin
				msg_bytes.push_back(8'hc0 | 8'($urandom_range(0, 63)));
				put_random(1);
			end
		end
	endtask

	task automatic put_question();
		put_name();
		put_random(4);
	endtask

	task automatic put_record(input logic [15:0] rtype, input logic [15:0] rdlen);
		put_name();
		put16(rtype);
		put_random(6);
		put16(rdlen);
		put_random(rdlen);
	endtask

	task automatic put_random_record();
		int pick, sel;
		pick = $urandom_range(0, 9);
		sel = $urandom_range(0, 9);
		if (pick < 3)
			put_record(TYPE_A, sel < 8 ? 16'd4 : (sel == 8 ? 16'($urandom_range(5, 12)) :
				16'($urandom_range(0, 3))));
		else if (pick < 6)
			put_record(TYPE_AAAA, sel < 8 ? 16'd16 : (sel == 8 ? 16'($urandom_range(17, 24)) :
				16'($urandom_range(0, 15))));
		else if (pick < 8)
			put_record(TYPE_CNAME, 16'($urandom_range(0, 12)));
		else
			put_record(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8)));
	endtask

	task automatic cut_message();
		int keep;
		keep = $urandom_range(1, msg_bytes.size());
		while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
	endtask

	task automatic put_random_message();
		int shape, qd, an;
		logic [15:0] flags;
		shape = $urandom_range(0, 19);
		flags = 16'($urandom_range(0, 65535));
		if (shape < 14) begin
			// Response with valid flags and random content; some are cut short.
			flags = (flags & 16'h7ff0) | 16'h8000;
			qd = $urandom_range(0, 2);
			an = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			put_header(flags, 16'(qd), 16'(an));
			repeat (qd) put_question();
			repeat (an) put_random_record();
			if ($urandom_range(0, 4) == 0)
				put_random($urandom_range(1, 4));
			if ($urandom_range(0, 9) == 0)
				cut_message();
		end else if (shape < 17) begin
			if ($urandom_range(0, 1) == 0) begin
				flags[15] = 1'b0;
			end else begin
				flags[15] = 1'b1;
				flags[3:0] = 4'($urandom_range(1, 15));
			end
			put_header(flags, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			put_random($urandom_range(0, 6));
		end else if (shape < 19) begin
			put_random($urandom_range(1, 30));
		end else begin
			// Random counts, mostly far beyond the body, so the message usually ends early.
			put_header((flags & 16'h7ff0) | 16'h8000, 16'($urandom_range(0, 65535)),
				16'($urandom_range(1, 65535)));
			repeat ($urandom_range(0, 2)) put_question();
			put_random_record();
		end
	endtask

	task automatic test_header_verdicts();
		put_header(16'h0000, 16'd1, 16'd1);
		send_message();
		put_header(16'h8000 | 16'(RCODE_SERVFAIL), 16'd1, 16'd1);
		send_message();
		put_header(16'h8000 | 16'(RCODE_NXDOMAIN), 16'd1, 16'd1);
		send_message();
		put_header(16'h8001, 16'd1, 16'd1);
		send_message();
		put_header(16'hffff, 16'hffff, 16'hffff);
		send_message();
		put_header(16'h8000, 16'hffff, 16'h0000);
		send_message();
		// A message that ends inside the header.
		msg_bytes.push_back(8'hff);
		send_message();
	endtask

	task automatic test_answer_records();
		put_header(16'h8180, 16'd1, 16'd5);
		put_question();
		put_record(TYPE_A, 16'd4);
		put_record(TYPE_AAAA, 16'd16);
		put_record(TYPE_CNAME, 16'd3);
		put_record(TYPE_A, 16'd7);
		put_record(16'hffff, 16'd0);
		send_message();
		// A label length byte with bit 6 set is still a length, not a pointer.
		put_header(16'h8000, 16'd1, 16'd1);
		msg_bytes.push_back(8'h40);
		put_random(64);
		msg_bytes.push_back(8'h00);
		put_random(4);
		put_record(TYPE_AAAA, 16'd20);
		send_message();
		put_header(16'h8000, 16'd0, 16'd1);
		put_record(TYPE_A, 16'd4);
		send_message();
		put_header(16'h8000, 16'd0, 16'd1);
		put_record(TYPE_CNAME, 16'd0);
		send_message();
	endtask

	task automatic test_short_rdata();
		put_header(16'h8000, 16'd0, 16'd2);
		put_record(TYPE_A, 16'd3);
		put_record(TYPE_A, 16'd4);
		send_message();
		put_header(16'h8000, 16'd0, 16'd1);
		put_record(TYPE_AAAA, 16'd15);
		send_message();
		put_header(16'h8000, 16'd1, 16'd1);
		put_question();
		put_record(TYPE_AAAA, 16'd0);
		send_message();
	endtask

	// Both kinds are accepted elsewhere; here each narrower setting gets one message.
	task automatic test_family_filter();
		logic [1:0] settings [0:2];
		settings = '{FILT_IPV4, FILT_IPV6, FILT_NONE};
		for (int i = 0; i < 3; i++) begin
			set_family_filter(settings[i]);
			put_header(16'h8000, 16'd0, 16'd3);
			put_record(TYPE_A, 16'd4);
			put_record(TYPE_AAAA, 16'd16);
			put_record(TYPE_A, 16'd2);
			send_message();
		end
		set_family_filter(FILT_BOTH);
	endtask

	task automatic test_truncation();
		// In the first message the end of message falls on the last address byte, so address and status share it.
		put_header(16'h8000, 16'd0, 16'd2);
		put_record(TYPE_A, 16'd4);
		send_message();
		put_header(16'h8000, 16'd0, 16'd1);
		put_record(TYPE_AAAA, 16'd16);
		repeat (5) void'(msg_bytes.pop_back());
		send_message();
	endtask

	task automatic test_random_messages();
		logic [1:0] order [0:4];
		int start, chunk;
		order = '{FILT_BOTH, FILT_IPV6, FILT_IPV4, FILT_NONE, FILT_BOTH};
		short_names = 1'b0;
		start = bytes_sent;
		chunk = 0;
		while (bytes_sent - start < RANDOM_BYTES) begin
			if (chunk < 5 && (bytes_sent - start) * 5 >= chunk * RANDOM_BYTES) begin
				set_family_filter(order[chunk]);
				chunk = chunk + 1;
			end
			if ((bytes_sent - start) * 5 >= RANDOM_BYTES * 4)
				allow_gaps = 1'b0;
			put_random_message();
			send_message();
		end
	endtask

	initial begin
		clear_parse_state();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_header_verdicts();
		test_answer_records();
		test_short_rdata();
		test_family_filter();
		test_truncation();
		test_random_messages();
		wait_until_idle();
		$display("Streamed %0d bytes in %0d messages and checked %0d results,", bytes_sent,
			messages_sent, results_checked);
		$display("covering all header verdicts, record kinds, short rdata and all filter values.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches in total.", error_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/drae_pkg.sv
hw/rtl/dns_response_address_extractor_unit.sv
test/dns_response_address_extractor_unit_tb.sv
